[hw/rtl/tour_permutation_mutation_engine_macros.svh]
// assertion macros used by the rtl file tpme_back
`ifndef TOUR_PERMUTATION_MUTATION_ENGINE_MACROS_SVH
`define TOUR_PERMUTATION_MUTATION_ENGINE_MACROS_SVH
`ifndef ASSERT_OFF
// clocked assertion, off while reset is asserted
`define TPME_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// clocked assertion that also holds during reset
`define TPME_ASSERT_NR(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TPME_ASSERT(lbl, clk, rst_n, prop, msg)
`define TPME_ASSERT_NR(lbl, clk, prop, msg)
`endif
`endif

[hw/rtl/tpme_pkg.sv]
package tpme_pkg;

    localparam int MAX_CITIES_DEF = 64;
    localparam int QUEUE_DEPTH    = 2;
    localparam int CFG_ADDR_W     = 3;
    localparam logic [6:0] CITIES_RESET = 7'd64;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_BOUNDS  = 3'd1;
    localparam logic [2:0] ST_OVERLAP = 3'd2;
    localparam logic [2:0] ST_FIRST   = 3'd3;
    localparam logic [2:0] ST_RANGE   = 3'd4;
    localparam logic [2:0] ST_DUP     = 3'd5;
    localparam logic [2:0] ST_MISSING = 3'd6;

    localparam logic [2:0] MODE_WRITE = 3'd0;
    localparam logic [2:0] MODE_READ  = 3'd1;
    localparam logic [2:0] MODE_SWAP  = 3'd2;
    localparam logic [2:0] MODE_REV   = 3'd3;
    localparam logic [2:0] MODE_EXCH  = 3'd4;
    localparam logic [2:0] MODE_MOVE  = 3'd5;
    localparam logic [2:0] MODE_FIND  = 3'd6;
    localparam logic [2:0] MODE_CHECK = 3'd7;

    localparam logic [2:0] CFG_REG_CITIES = 3'd0;

    typedef enum logic [2:0] {
        K_RESULT = 3'd0,
        K_WRITE  = 3'd1,
        K_READ   = 3'd2,
        K_SWAPS  = 3'd3,
        K_MOVE   = 3'd4,
        K_FIND   = 3'd5,
        K_CHECK  = 3'd6
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [2:0] status;
        logic [6:0] p;
        logic [6:0] q;
        logic       qdown;
        logic [6:0] cnt;
        logic [6:0] lo;
        logic [6:0] mid;
        logic [6:0] hi;
        logic [6:0] cval;
        logic [6:0] n;
    } t_cmd;

    typedef struct packed {
        logic [2:0] status;
        logic [6:0] value;
    } t_res;

endpackage

[hw/rtl/tpme_ram.sv]
module tpme_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

[hw/rtl/tpme_queue.sv]
module tpme_queue
    import tpme_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr, r_rd;
    logic [CW-1:0]    r_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + PW'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + PW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end
endmodule

[hw/rtl/tpme_front.sv]
module tpme_front
    import tpme_pkg::*;
#(
    parameter int MAX_CITIES = MAX_CITIES_DEF
) (
    input  logic       i_push,
    output logic       o_full,
    input  logic [2:0] i_mode,
    input  logic [5:0] i_first_index,
    input  logic [6:0] i_second_index,
    input  logic [6:0] i_destination,
    input  logic [6:0] i_city_value,
    input  logic [6:0] i_cities,
    output logic       o_cmd_push,
    output t_cmd       o_cmd,
    input  logic       i_cmd_full
);
    logic [6:0] n;
    logic [7:0] a8, b8, d8, n8, ab8, db8;

    assign o_full     = i_cmd_full;
    assign o_cmd_push = i_push && !i_cmd_full;

    always_comb begin
        if (i_cities < 7'd2) begin
            n = 7'd2;
        end else if (int'(i_cities) > MAX_CITIES) begin
            n = 7'(MAX_CITIES);
        end else begin
            n = i_cities;
        end
    end

    assign a8  = {2'b00, i_first_index};
    assign b8  = {1'b0, i_second_index};
    assign d8  = {1'b0, i_destination};
    assign n8  = {1'b0, n};
    assign ab8 = a8 + b8;
    assign db8 = d8 + b8;

    // classify: bounds, overlap and range errors become a finished result
    always_comb begin
        o_cmd        = '0;
        o_cmd.kind   = K_RESULT;
        o_cmd.status = ST_OK;
        o_cmd.n      = n;
        o_cmd.p      = {1'b0, i_first_index};
        o_cmd.cval   = i_city_value;
        case (i_mode)
            MODE_WRITE, MODE_READ: begin
                if (a8 >= n8) begin
                    o_cmd.status = ST_BOUNDS;
                end else begin
                    o_cmd.kind = (i_mode == MODE_WRITE) ? K_WRITE : K_READ;
                end
            end
            MODE_SWAP: begin
                if (a8 >= n8 || b8 >= n8) begin
                    o_cmd.status = ST_BOUNDS;
                end else begin
                    o_cmd.kind = K_SWAPS;
                    o_cmd.q    = i_second_index;
                    o_cmd.cnt  = 7'd1;
                end
            end
            MODE_REV: begin
                if (ab8 > n8) begin
                    o_cmd.status = ST_BOUNDS;
                end else begin
                    o_cmd.kind  = K_SWAPS;
                    o_cmd.q     = ab8[6:0] - 7'd1;
                    o_cmd.qdown = 1'b1;
                    o_cmd.cnt   = i_second_index >> 1;
                end
            end
            MODE_EXCH: begin
                if (ab8 > n8 || db8 > n8) begin
                    o_cmd.status = ST_BOUNDS;
                end else if (d8 >= a8 && d8 < ab8) begin
                    o_cmd.status = ST_OVERLAP;
                end else begin
                    o_cmd.kind = K_SWAPS;
                    o_cmd.q    = i_destination;
                    o_cmd.cnt  = i_second_index;
                end
            end
            MODE_MOVE: begin
                if (ab8 > n8 || d8 > n8) begin
                    o_cmd.status = ST_BOUNDS;
                end else if (d8 >= a8 && d8 <= ab8) begin
                    o_cmd.status = ST_OVERLAP;
                end else begin
                    // a move is a rotation: three block reversals
                    o_cmd.kind = K_MOVE;
                    if (d8 < a8) begin
                        o_cmd.lo  = i_destination;
                        o_cmd.mid = {1'b0, i_first_index};
                        o_cmd.hi  = ab8[6:0];
                    end else begin
                        o_cmd.lo  = {1'b0, i_first_index};
                        o_cmd.mid = ab8[6:0];
                        o_cmd.hi  = i_destination;
                    end
                end
            end
            MODE_FIND: begin
                if (i_city_value == 7'd0 || i_city_value > n) begin
                    o_cmd.status = ST_RANGE;
                end else begin
                    o_cmd.kind = K_FIND;
                end
            end
            default: begin
                o_cmd.kind = K_CHECK;
            end
        endcase
    end
endmodule

[hw/rtl/tpme_back.sv]
`include "tour_permutation_mutation_engine_macros.svh"
module tpme_back
    import tpme_pkg::*;
#(
    parameter int MAX_CITIES = MAX_CITIES_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_cmd_valid,
    input  t_cmd i_cmd,
    output logic o_cmd_pop,
    output logic o_res_push,
    output t_res o_res,
    input  logic i_res_full
);
    localparam int AW = $clog2(MAX_CITIES);

    typedef enum logic [14:0] {
        S_IDLE = 15'b000000000000001,
        S_WR   = 15'b000000000000010,
        S_RA   = 15'b000000000000100,
        S_RB   = 15'b000000000001000,
        S_MSET = 15'b000000000010000,
        S_JOB  = 15'b000000000100000,
        S_SWA  = 15'b000000001000000,
        S_SWB  = 15'b000000010000000,
        S_SWC  = 15'b000000100000000,
        S_SWD  = 15'b000001000000000,
        S_CLR  = 15'b000010000000000,
        S_SCA  = 15'b000100000000000,
        S_SCB  = 15'b001000000000000,
        S_SEEN = 15'b010000000000000,
        S_OUT  = 15'b100000000000000
    } t_state;

    t_state     r_state, n_state;
    t_kind      r_kind, n_kind;
    logic [6:0] r_p, n_p, r_q, n_q, r_cnt, n_cnt;
    logic       r_qdown, n_qdown;
    logic [6:0] r_lo, n_lo, r_mid, n_mid, r_hi, n_hi;
    logic [6:0] r_cval, n_cval, r_n, n_n;
    logic [1:0] r_phase, n_phase;
    logic [6:0] r_i, n_i, r_va, n_va, r_v, n_v;
    logic [2:0] r_st, n_st;
    logic [6:0] r_val, n_val;

    logic          tour_we, seen_we, seen_wdata, seen_rdata;
    logic [AW-1:0] tour_addr, seen_addr;
    logic [6:0]    tour_wdata, tour_rdata;
    logic [6:0]    rx, ry;

    tpme_ram #(.WIDTH(7), .DEPTH(MAX_CITIES)) u_tour (
        .i_clk  (i_clk),
        .i_we   (tour_we),
        .i_addr (tour_addr),
        .i_wdata(tour_wdata),
        .o_rdata(tour_rdata)
    );

    tpme_ram #(.WIDTH(1), .DEPTH(MAX_CITIES)) u_seen (
        .i_clk  (i_clk),
        .i_we   (seen_we),
        .i_addr (seen_addr),
        .i_wdata(seen_wdata),
        .o_rdata(seen_rdata)
    );

    assign o_cmd_pop    = (r_state == S_IDLE) && i_cmd_valid;
    assign o_res_push   = (r_state == S_OUT) && !i_res_full;
    assign o_res.status = r_st;
    assign o_res.value  = r_val;

    // bounds of the reversal for the current move phase
    always_comb begin
        case (r_phase)
            2'd0:    begin rx = r_lo;  ry = r_mid; end
            2'd1:    begin rx = r_mid; ry = r_hi;  end
            default: begin rx = r_lo;  ry = r_hi;  end
        endcase
    end

    always_comb begin
        n_state = r_state;
        n_kind  = r_kind;
        n_p     = r_p;
        n_q     = r_q;
        n_cnt   = r_cnt;
        n_qdown = r_qdown;
        n_lo    = r_lo;
        n_mid   = r_mid;
        n_hi    = r_hi;
        n_cval  = r_cval;
        n_n     = r_n;
        n_phase = r_phase;
        n_i     = r_i;
        n_va    = r_va;
        n_v     = r_v;
        n_st    = r_st;
        n_val   = r_val;

        tour_we    = 1'b0;
        tour_addr  = AW'(r_p);
        tour_wdata = r_cval;
        seen_we    = 1'b0;
        seen_addr  = AW'(r_i);
        seen_wdata = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    n_kind  = i_cmd.kind;
                    n_p     = i_cmd.p;
                    n_q     = i_cmd.q;
                    n_cnt   = i_cmd.cnt;
                    n_qdown = i_cmd.qdown;
                    n_lo    = i_cmd.lo;
                    n_mid   = i_cmd.mid;
                    n_hi    = i_cmd.hi;
                    n_cval  = i_cmd.cval;
                    n_n     = i_cmd.n;
                    n_phase = 2'd0;
                    n_i     = 7'd0;
                    n_st    = i_cmd.status;
                    n_val   = 7'd0;
                    case (i_cmd.kind)
                        K_WRITE: n_state = S_WR;
                        K_READ:  n_state = S_RA;
                        K_SWAPS: n_state = S_JOB;
                        K_MOVE:  n_state = S_MSET;
                        K_FIND:  n_state = S_SCA;
                        K_CHECK: n_state = S_CLR;
                        default: n_state = S_OUT;
                    endcase
                end
            end
            S_WR: begin
                tour_we = 1'b1;
                n_state = S_OUT;
            end
            S_RA: begin
                n_state = S_RB;
            end
            S_RB: begin
                n_val   = tour_rdata;
                n_state = S_OUT;
            end
            S_MSET: begin
                n_p     = rx;
                n_q     = ry - 7'd1;
                n_cnt   = (ry - rx) >> 1;
                n_qdown = 1'b1;
                n_state = S_JOB;
            end
            S_JOB: begin
                if (r_cnt == 7'd0) begin
                    if (r_kind == K_MOVE && r_phase != 2'd2) begin
                        n_phase = r_phase + 2'd1;
                        n_state = S_MSET;
                    end else begin
                        n_state = S_OUT;
                    end
                end else begin
                    n_state = S_SWA;
                end
            end
            S_SWA: begin
                n_state = S_SWB;
            end
            S_SWB: begin
                tour_addr = AW'(r_q);
                n_va      = tour_rdata;
                n_state   = S_SWC;
            end
            S_SWC: begin
                tour_we    = 1'b1;
                tour_wdata = tour_rdata;
                n_state    = S_SWD;
            end
            S_SWD: begin
                tour_we    = 1'b1;
                tour_addr  = AW'(r_q);
                tour_wdata = r_va;
                n_p        = r_p + 7'd1;
                n_q        = r_qdown ? r_q - 7'd1 : r_q + 7'd1;
                n_cnt      = r_cnt - 7'd1;
                n_state    = S_JOB;
            end
            S_CLR: begin
                seen_we = 1'b1;
                if (r_i + 7'd1 == r_n) begin
                    n_i     = 7'd0;
                    n_state = S_SCA;
                end else begin
                    n_i = r_i + 7'd1;
                end
            end
            S_SCA: begin
                tour_addr = AW'(r_i);
                n_state   = S_SCB;
            end
            S_SCB: begin
                seen_addr = AW'(tour_rdata - 7'd1);
                n_v       = tour_rdata;
                if (r_kind == K_FIND) begin
                    if (tour_rdata == r_cval) begin
                        n_val   = r_i;
                        n_state = S_OUT;
                    end else if (r_i + 7'd1 == r_n) begin
                        n_st    = ST_MISSING;
                        n_state = S_OUT;
                    end else begin
                        n_i     = r_i + 7'd1;
                        n_state = S_SCA;
                    end
                end else if (r_i == 7'd0 && tour_rdata != 7'd1) begin
                    n_st    = ST_FIRST;
                    n_state = S_OUT;
                end else if (tour_rdata == 7'd0 || tour_rdata > r_n) begin
                    n_st    = ST_RANGE;
                    n_state = S_OUT;
                end else begin
                    n_state = S_SEEN;
                end
            end
            S_SEEN: begin
                seen_addr = AW'(r_v - 7'd1);
                if (seen_rdata) begin
                    n_st    = ST_DUP;
                    n_state = S_OUT;
                end else begin
                    seen_we    = 1'b1;
                    seen_wdata = 1'b1;
                    if (r_i + 7'd1 == r_n) begin
                        n_state = S_OUT;
                    end else begin
                        n_i     = r_i + 7'd1;
                        n_state = S_SCA;
                    end
                end
            end
            S_OUT: begin
                if (!i_res_full) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind  <= n_kind;
        r_p     <= n_p;
        r_q     <= n_q;
        r_cnt   <= n_cnt;
        r_qdown <= n_qdown;
        r_lo    <= n_lo;
        r_mid   <= n_mid;
        r_hi    <= n_hi;
        r_cval  <= n_cval;
        r_n     <= n_n;
        r_phase <= n_phase;
        r_i     <= n_i;
        r_va    <= n_va;
        r_v     <= n_v;
        r_st    <= n_st;
        r_val   <= n_val;
    end

    `TPME_ASSERT_NR(a_rst_idle, i_clk, !i_rst_n |=> r_state == S_IDLE, "not idle after reset")
    `TPME_ASSERT(a_pop_valid, i_clk, i_rst_n, o_cmd_pop |-> i_cmd_valid, "pop of empty queue")
    `TPME_ASSERT(a_push_room, i_clk, i_rst_n, o_res_push |-> !i_res_full, "push into full queue")
    `TPME_ASSERT(a_seen_range, i_clk, i_rst_n, r_state == S_SEEN |-> (r_v != 7'd0 && r_v <= r_n), "seen mark outside tour")
    `TPME_ASSERT(a_swap_count, i_clk, i_rst_n, r_state == S_SWA |-> r_cnt != 7'd0, "swap with no count left")
endmodule

[hw/rtl/tour_permutation_mutation_engine.sv]
// tour permutation engine: holds a tour of up to MAX_CITIES city numbers and
// applies one operation per item (write, read, swap, reverse, exchange, move,
// find, check), returning one result item (status, value) for each.
// input channel: an item is taken when push is high and full is low.
// result channel: the oldest result sits on o_status / o_result_value while
// empty is low and leaves when pop is high.
// the front decodes and bounds-checks an item in the accept cycle and queues a
// command; the back walks the single-port tour store, one access per cycle.
// the time per item is set by that one store port: a swap reads both entries
// and writes both back, reverse and exchange repeat that per pair, a move runs
// three reversals, find scans until a match, check clears the seen marks then
// scans the cities; a bounds error skips the store. the back takes a new command only when idle.
// a stalled result queue halts the back; the command queue keeps taking
// items until it too fills, then full rises.
// reset (synchronous, active low) empties both queues and sets the city count
// to 64; the tour store holds nothing defined until written.
// cities_in_use lies at byte address 0 of the apb port; it is used clamped
// into 2..MAX_CITIES.
module tour_permutation_mutation_engine
    import tpme_pkg::*;
#(
    parameter int MAX_CITIES = MAX_CITIES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input items
    input  logic                  push,
    output logic                  full,
    input  logic [2:0]            i_mode,
    input  logic [5:0]            i_first_index,
    input  logic [6:0]            i_second_index,
    input  logic [6:0]            i_destination,
    input  logic [6:0]            i_city_value,
    // result items
    output logic                  empty,
    input  logic                  pop,
    output logic [2:0]            o_status,
    output logic [6:0]            o_result_value,
    // configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);
    logic [6:0] r_cities;
    logic       cfg_hit;

    t_cmd front_cmd, back_cmd;
    logic front_push, cmd_full, cmd_empty, cmd_pop;
    t_res back_res, out_res;
    logic res_push, res_full;

    // register index is the word address
    assign cfg_hit = (paddr[CFG_ADDR_W-1:2] == CFG_REG_CITIES[CFG_ADDR_W-3:0]);
    assign pready  = 1'b1;
    assign prdata  = cfg_hit ? {25'd0, r_cities} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cities <= CITIES_RESET;
        end else if (psel && penable && pwrite && cfg_hit) begin
            r_cities <= pwdata[6:0];
        end
    end

    // decode and bounds checks
    tpme_front #(.MAX_CITIES(MAX_CITIES)) u_front (
        .i_push        (push),
        .o_full        (full),
        .i_mode        (i_mode),
        .i_first_index (i_first_index),
        .i_second_index(i_second_index),
        .i_destination (i_destination),
        .i_city_value  (i_city_value),
        .i_cities      (r_cities),
        .o_cmd_push    (front_push),
        .o_cmd         (front_cmd),
        .i_cmd_full    (cmd_full)
    );

    // short command queue between decode and execution
    tpme_queue #(.WIDTH($bits(t_cmd)), .DEPTH(QUEUE_DEPTH)) u_cmd_q (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (front_push),
        .i_data (front_cmd),
        .o_full (cmd_full),
        .i_pop  (cmd_pop),
        .o_data (back_cmd),
        .o_empty(cmd_empty)
    );

    // sequencer on the tour and seen-mark stores
    tpme_back #(.MAX_CITIES(MAX_CITIES)) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd_valid(!cmd_empty),
        .i_cmd      (back_cmd),
        .o_cmd_pop  (cmd_pop),
        .o_res_push (res_push),
        .o_res      (back_res),
        .i_res_full (res_full)
    );

    // result queue decouples the back from a stalled receiver
    tpme_queue #(.WIDTH($bits(t_res)), .DEPTH(QUEUE_DEPTH)) u_res_q (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (res_push),
        .i_data (back_res),
        .o_full (res_full),
        .i_pop  (pop),
        .o_data (out_res),
        .o_empty(empty)
    );

    assign o_status       = out_res.status;
    assign o_result_value = out_res.value;
endmodule
